FILE: hdl/ukfq_pkg.sv
// Shared types, widths and codes for the unique-key FIFO queue.
package ukfq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 5;
  localparam int CNT_W   = 5;
  localparam int ENTRY_W = KEY_W + VAL_W;

  localparam int IN_DATA_W  = ((KEY_W + VAL_W + POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((KEY_W + VAL_W + CNT_W + 7) / 8) * 8;

  // Depth of the command queue between front and back.
  localparam int CQ_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [POS_W-1:0]   pos;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH
  } state_t;

endpackage

FILE: hdl/unique_key_fifo_queue_top.sv
// Top level of the unique-key FIFO queue: stream ports, front end, back end and entry RAM.
//
//   channel  | direction | tdata (low bit up)                           | tuser
//   ---------+-----------+----------------------------------------------+-----------
//   in_      | slave     | key_in, value_in, position, zero pad         | operation
//   out_     | master    | key_out, value_out, entry_count, zero pad    | ok
//
// A pop or a read passes through the fetch state of the back end; a command refused at the
// start (full, empty, bad position, unused code) is answered from the idle state. A push
// first scans the stored entries for a duplicate key through the single RAM read port,
// one stored entry per cycle, and writes the new entry only if none of them matches.
// Reset (rst_n low at a clock edge) empties the queue; RAM contents are not cleared.
// The front end queues up to two commands; in_tready drops only once two are waiting.
module unique_key_fifo_queue_top #(
  parameter int QUEUE_DEPTH = ukfq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] key_in, [63:32] value_in, [68:64] position, [71:69] zero
  input  logic [ukfq_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] operation
  input  logic [ukfq_pkg::OP_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] key_out, [63:32] value_out, [68:64] entry_count, [71:69] zero
  output logic [ukfq_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [0] ok
  output logic [0:0]                        out_tuser
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int PAD_W = ukfq_pkg::OUT_DATA_W - ukfq_pkg::KEY_W - ukfq_pkg::VAL_W
                       - ukfq_pkg::CNT_W;
  localparam int VAL_LO = ukfq_pkg::KEY_W;
  localparam int POS_LO = ukfq_pkg::KEY_W + ukfq_pkg::VAL_W;

  logic                         cmd_valid;
  ukfq_pkg::cmd_t               cmd;
  logic                         cmd_take;
  logic                         ram_wr_en;
  logic [AW-1:0]                ram_wr_addr;
  logic [ukfq_pkg::ENTRY_W-1:0] ram_wr_data;
  logic                         ram_rd_en;
  logic [AW-1:0]                ram_rd_addr;
  logic [ukfq_pkg::ENTRY_W-1:0] ram_rd_data;
  logic                         res_ok;
  logic [ukfq_pkg::KEY_W-1:0]   res_key;
  logic [ukfq_pkg::VAL_W-1:0]   res_value;
  logic [ukfq_pkg::CNT_W-1:0]   res_count;

  // The front end classifies each input transfer, sliced into fields here, into a command.
  ukfq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_key    (in_tdata[ukfq_pkg::KEY_W-1:0]),
    .in_value  (in_tdata[POS_LO-1:VAL_LO]),
    .in_pos    (in_tdata[POS_LO+ukfq_pkg::POS_W-1:POS_LO]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // The back end owns the pointers and count, scans for duplicates and builds results.
  ukfq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_ok      (res_ok),
    .out_key     (res_key),
    .out_value   (res_value),
    .out_count   (res_count)
  );

  // Each entry holds its value above its key in one RAM word.
  ukfq_ram #(
    .WIDTH (ukfq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res_count, res_value, res_key};
  assign out_tuser = res_ok;

endmodule

FILE: hdl/ukfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ukfq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/ukfq_front.sv
// Front end: accepts input transfers, classifies the operation and queues commands.
module ukfq_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ukfq_pkg::OP_W-1:0]   in_op,
  input  logic [ukfq_pkg::KEY_W-1:0]  in_key,
  input  logic [ukfq_pkg::VAL_W-1:0]  in_value,
  input  logic [ukfq_pkg::POS_W-1:0]  in_pos,
  output logic                        cmd_valid,
  output ukfq_pkg::cmd_t              cmd,
  input  logic                        cmd_take
);

  localparam int PW = $clog2(ukfq_pkg::CQ_DEPTH);
  localparam int QW = $clog2(ukfq_pkg::CQ_DEPTH + 1);

  ukfq_pkg::cmd_t q_r [ukfq_pkg::CQ_DEPTH];
  ukfq_pkg::cmd_t cls;
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QW-1:0]  cnt_r, cnt_nxt;
  logic           push;
  logic           pop;

  // Classify the raw operation code; the unused code becomes a no-op.
  always_comb begin
    cls.key   = in_key;
    cls.value = in_value;
    cls.pos   = in_pos;
    unique case (in_op)
      ukfq_pkg::OP_PUSH: cls.kind = ukfq_pkg::CMD_PUSH;
      ukfq_pkg::OP_POP:  cls.kind = ukfq_pkg::CMD_POP;
      ukfq_pkg::OP_READ: cls.kind = ukfq_pkg::CMD_READ;
      default:           cls.kind = ukfq_pkg::CMD_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != QW'(ukfq_pkg::CQ_DEPTH));
  assign push      = in_valid && in_ready;
  assign pop       = cmd_take && cmd_valid;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(ukfq_pkg::CQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(ukfq_pkg::CQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QW'(push) - QW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

FILE: hdl/ukfq_back.sv
// Back end: executes queued commands against the entry RAM and holds the result register.
module ukfq_back #(
  parameter int QUEUE_DEPTH = ukfq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  ukfq_pkg::cmd_t                    cmd,
  output logic                              cmd_take,
  output logic                              ram_wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]    ram_wr_addr,
  output logic [ukfq_pkg::ENTRY_W-1:0]      ram_wr_data,
  output logic                              ram_rd_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]    ram_rd_addr,
  input  logic [ukfq_pkg::ENTRY_W-1:0]      ram_rd_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_ok,
  output logic [ukfq_pkg::KEY_W-1:0]        out_key,
  output logic [ukfq_pkg::VAL_W-1:0]        out_value,
  output logic [ukfq_pkg::CNT_W-1:0]        out_count
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = AW + ukfq_pkg::POS_W + 1;
  localparam int EW = CW + ukfq_pkg::POS_W;

  ukfq_pkg::state_t state_r, state_nxt;
  ukfq_pkg::cmd_t   cur_r, cur_nxt;

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] scan_addr_r, scan_addr_nxt;
  logic [CW-1:0] scan_left_r, scan_left_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic          hit_r, hit_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_ok_r, out_ok_nxt;
  logic [ukfq_pkg::KEY_W-1:0] out_key_r, out_key_nxt;
  logic [ukfq_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic [ukfq_pkg::CNT_W-1:0] out_count_r, out_count_nxt;

  logic          start;
  logic          full;
  logic          empty;
  logic          pos_ok;
  logic [EW-1:0] pos_ext;
  logic [EW-1:0] cnt_ext;
  logic [SW-1:0] rd_sum;
  logic [SW-1:0] rd_slot;
  logic          issue;
  logic          scan_done;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Count as reported on the port: zero-extended, then cut to the port width.
  function automatic logic [ukfq_pkg::CNT_W-1:0] cnt_port(input logic [CW-1:0] c);
    logic [EW-1:0] w;
    w = {{ukfq_pkg::CNT_W{1'b0}}, c};
    cnt_port = w[ukfq_pkg::CNT_W-1:0];
  endfunction

  assign start = (state_r == ukfq_pkg::ST_IDLE) && cmd_valid && (!out_valid_r || out_ready);
  assign full  = (count_r == CW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  assign pos_ext = {{CW{1'b0}}, cmd.pos};
  assign cnt_ext = {{ukfq_pkg::POS_W{1'b0}}, count_r};
  assign pos_ok  = (cmd.pos != '0) && (pos_ext <= cnt_ext);

  // Slot of a read: head plus position minus one, wrapped once.
  assign rd_sum  = {{(ukfq_pkg::POS_W + 1){1'b0}}, head_r}
                 + {{(AW + 1){1'b0}}, cmd.pos - 1'b1};
  assign rd_slot = (rd_sum >= SW'(QUEUE_DEPTH)) ? rd_sum - SW'(QUEUE_DEPTH) : rd_sum;

  assign issue     = (scan_left_r != '0);
  assign scan_done = !issue && !cmp_vld_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ukfq_pkg::ST_IDLE: begin
        if (start) begin
          unique case (cmd.kind)
            ukfq_pkg::CMD_PUSH: if (!full)  state_nxt = ukfq_pkg::ST_SCAN;
            ukfq_pkg::CMD_POP:  if (!empty) state_nxt = ukfq_pkg::ST_FETCH;
            ukfq_pkg::CMD_READ: if (pos_ok) state_nxt = ukfq_pkg::ST_FETCH;
            default:            state_nxt = ukfq_pkg::ST_IDLE;
          endcase
        end
      end
      ukfq_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = ukfq_pkg::ST_IDLE;
      end
      ukfq_pkg::ST_FETCH: state_nxt = ukfq_pkg::ST_IDLE;
      default:            state_nxt = ukfq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_take      = start;
    cur_nxt       = cur_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    scan_addr_nxt = scan_addr_r;
    scan_left_nxt = scan_left_r;
    cmp_vld_nxt   = 1'b0;
    hit_nxt       = hit_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = scan_addr_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = tail_r;
    ram_wr_data   = {cur_r.value, cur_r.key};
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_key_nxt   = out_key_r;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;

    unique case (state_r)
      ukfq_pkg::ST_IDLE: begin
        if (start) begin
          cur_nxt       = cmd;
          scan_addr_nxt = head_r;
          scan_left_nxt = count_r;
          hit_nxt       = 1'b0;
          // Default result is a failure; cleared below when work continues.
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_key_nxt   = '0;
          out_value_nxt = '0;
          out_count_nxt = cnt_port(count_r);
          unique case (cmd.kind)
            ukfq_pkg::CMD_PUSH: begin
              if (!full) out_valid_nxt = 1'b0;
            end
            ukfq_pkg::CMD_POP: begin
              if (!empty) begin
                out_valid_nxt = 1'b0;
                ram_rd_en     = 1'b1;
                ram_rd_addr   = head_r;
              end
            end
            ukfq_pkg::CMD_READ: begin
              if (pos_ok) begin
                out_valid_nxt = 1'b0;
                ram_rd_en     = 1'b1;
                ram_rd_addr   = rd_slot[AW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      ukfq_pkg::ST_SCAN: begin
        // One key read per cycle; the compare acts on each read's data in the cycle after it.
        ram_rd_en   = issue;
        cmp_vld_nxt = issue;
        if (issue) begin
          scan_addr_nxt = ptr_inc(scan_addr_r);
          scan_left_nxt = scan_left_r - 1'b1;
        end
        hit_nxt = hit_r || (cmp_vld_r && (ram_rd_data[ukfq_pkg::KEY_W-1:0] == cur_r.key));
        if (scan_done) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = '0;
          out_value_nxt = '0;
          if (hit_r) begin
            out_ok_nxt    = 1'b0;
            out_count_nxt = cnt_port(count_r);
          end else begin
            ram_wr_en     = 1'b1;
            tail_nxt      = ptr_inc(tail_r);
            count_nxt     = count_r + 1'b1;
            out_ok_nxt    = 1'b1;
            out_count_nxt = cnt_port(count_r + 1'b1);
          end
        end
      end
      ukfq_pkg::ST_FETCH: begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        out_key_nxt   = ram_rd_data[ukfq_pkg::KEY_W-1:0];
        out_value_nxt = ram_rd_data[ukfq_pkg::ENTRY_W-1:ukfq_pkg::KEY_W];
        out_count_nxt = cnt_port(count_r);
        if (cur_r.kind == ukfq_pkg::CMD_POP) begin
          head_nxt      = ptr_inc(head_r);
          count_nxt     = count_r - 1'b1;
          out_count_nxt = cnt_port(count_r - 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ukfq_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      scan_left_r <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      scan_left_r <= scan_left_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    scan_addr_r <= scan_addr_nxt;
    out_ok_r    <= out_ok_nxt;
    out_key_r   <= out_key_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_key   = out_key_r;
  assign out_value = out_value_r;
  assign out_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ukfq_pkg::ST_IDLE) |-> !out_valid_r)
    else $error("result register occupied while a command is in flight");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1)
                     || (count_r == $past(count_r) - 1'b1))
    else $error("entry count moved by more than one");

  a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ukfq_pkg::ST_SCAN && !scan_done) |=> (state_r == ukfq_pkg::ST_SCAN))
    else $error("duplicate scan left before it finished");

endmodule

FILE: sim/unique_key_fifo_queue_top_tb.sv
// Self-checking testbench for the unique-key FIFO queue, driven and checked on its stream ports.
module unique_key_fifo_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = ukfq_pkg::QUEUE_DEPTH_DEF;
  localparam int OP_W       = ukfq_pkg::OP_W;
  localparam int KEY_W      = ukfq_pkg::KEY_W;
  localparam int VAL_W      = ukfq_pkg::VAL_W;
  localparam int POS_W      = ukfq_pkg::POS_W;
  localparam int CNT_W      = ukfq_pkg::CNT_W;
  localparam int IN_DATA_W  = ukfq_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = ukfq_pkg::OUT_DATA_W;
  // Operation code three is not decoded by the block; it must answer with a plain failure.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  // Between two transfers a correct run is quiet longest for a push that scans fifteen
  // entries followed by a long result stall.
  localparam int STALL_LIMIT = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } queue_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  unique_key_fifo_queue_top #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the queue contents, updated as each input transfer is accepted.
  logic [KEY_W-1:0] shadow_key [DEPTH];
  logic [VAL_W-1:0] shadow_val [DEPTH];
  int               shadow_head;
  int               shadow_tail;
  int               shadow_count;

  // Results the block still owes us, oldest first.
  queue_result_t pending_results [$];
  int            fail_count = 0;
  // When cleared, neither side inserts idle cycles.
  bit            idle_en = 1'b1;

  // Computes the result of one operation and advances the shadow queue accordingly.
  function automatic queue_result_t compute_queue_result(input logic [OP_W-1:0]  op,
                                                         input logic [KEY_W-1:0] key,
                                                         input logic [VAL_W-1:0] val,
                                                         input logic [POS_W-1:0] pos);
    queue_result_t r;
    bit            dup;
    int            slot;
    r = '0;
    dup = 1'b0;
    case (op)
      ukfq_pkg::OP_PUSH: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_key[(shadow_head + i) % DEPTH] == key) dup = 1'b1;
        end
        // A full queue and a duplicate key are both rejected with the state untouched.
        if (shadow_count < DEPTH && !dup) begin
          shadow_key[shadow_tail] = key;
          shadow_val[shadow_tail] = val;
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      ukfq_pkg::OP_POP: begin
        if (shadow_count > 0) begin
          r.ok = 1'b1;
          r.key = shadow_key[shadow_head];
          r.value = shadow_val[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      ukfq_pkg::OP_READ: begin
        // Position is 1-based from the oldest entry; zero or past the count fails.
        if (pos >= 1 && pos <= shadow_count) begin
          slot = (shadow_head + pos - 1) % DEPTH;
          r.ok = 1'b1;
          r.key = shadow_key[slot];
          r.value = shadow_val[slot];
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(shadow_count);
    return r;
  endfunction

  // Presents one item on the input channel and waits for its transfer. An idle burst may
  // come first; otherwise tvalid stays high from the previous item without a drop.
  task automatic send_item(input logic [OP_W-1:0]  op,
                           input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, pos, val, key};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(compute_queue_result(op, key, val, pos));
  endtask

  // Picks a key: often one already stored, to provoke duplicate rejection, sometimes an
  // extreme 32-bit pattern, otherwise anything.
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3 && shadow_count > 0)
      return shadow_key[(shadow_head + $urandom_range(0, shadow_count - 1)) % DEPTH];
    if (sel == 3) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (sel == 4) return KEY_W'($urandom_range(0, 31));
    return $urandom;
  endfunction

  // Sends one random item; the weights set the operation mix.
  task automatic send_random(input int push_w, input int pop_w, input int read_w,
                             input int spare_w);
    int               roll;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(0, push_w + pop_w + read_w + spare_w - 1);
    if (roll < push_w) op = ukfq_pkg::OP_PUSH;
    else if (roll < push_w + pop_w) op = ukfq_pkg::OP_POP;
    else if (roll < push_w + pop_w + read_w) op = ukfq_pkg::OP_READ;
    else op = OP_SPARE;
    // Mostly positions around the live range, now and then any 5-bit value.
    if ($urandom_range(0, 5) == 0) pos = POS_W'($urandom_range(0, 31));
    else pos = POS_W'($urandom_range(0, shadow_count + 1));
    send_item(op, pick_key(), $urandom, pos);
  endtask

  // Pop, reads and the unused code on a queue that holds nothing.
  task automatic test_empty_queue();
    send_item(ukfq_pkg::OP_POP,  32'h1234_5678, 32'h9ABC_DEF0, 5'd1);
    send_item(ukfq_pkg::OP_READ, 32'h0,         32'h0,         5'd0);
    send_item(ukfq_pkg::OP_READ, 32'h0,         32'h0,         5'd1);
    send_item(ukfq_pkg::OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    send_item(OP_SPARE,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
  endtask

  // Extreme keys and values, a duplicate push, reads at the edges of the count.
  task automatic test_extremes();
    send_item(ukfq_pkg::OP_PUSH, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0);
    send_item(ukfq_pkg::OP_PUSH, 32'h7FFF_FFFF, 32'h8000_0000, 5'd31);
    send_item(ukfq_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'h0000_0000, 5'd16);
    send_item(ukfq_pkg::OP_PUSH, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0);
    send_item(ukfq_pkg::OP_PUSH, 32'h8000_0000, 32'h1111_1111, 5'd0);
    send_item(ukfq_pkg::OP_READ, 32'h0,         32'h0,         5'd0);
    send_item(ukfq_pkg::OP_READ, 32'h0,         32'h0,         5'd1);
    send_item(ukfq_pkg::OP_READ, 32'h0,         32'h0,         5'd4);
    send_item(ukfq_pkg::OP_READ, 32'h0,         32'h0,         5'd5);
    send_item(OP_SPARE,          32'h8000_0000, 32'h0,         5'd1);
    send_item(ukfq_pkg::OP_POP,  32'h0,         32'h0,         5'd0);
    send_item(ukfq_pkg::OP_PUSH, 32'h8000_0000, 32'hAAAA_5555, 5'd0);
    send_item(ukfq_pkg::OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd4);
  endtask

  // Repeatedly fills the queue past full, reads across it, then drains past empty, so the
  // pointers wrap and the full and empty rejections are seen many times.
  task automatic test_fill_and_drain(input int rounds);
    repeat (rounds) begin
      while (shadow_count < DEPTH) send_random(1, 0, 0, 0);
      repeat (2) send_random(1, 0, 0, 0);
      send_item(ukfq_pkg::OP_READ, 32'h0, 32'h0, 5'd16);
      send_item(ukfq_pkg::OP_READ, 32'h0, 32'h0, 5'd17);
      repeat (3) send_random(0, 0, 1, 0);
      while (shadow_count > 0) send_random(0, 4, 1, 0);
      send_item(ukfq_pkg::OP_POP, 32'h0, 32'h0, 5'd0);
    end
  endtask

  // Mixed random traffic with the given number of items.
  task automatic test_random_mix(input int items);
    repeat (items) send_random(9, 6, 4, 1);
  endtask

  // The last stretch runs with no idle cycles inserted on either side.
  task automatic test_back_to_back(input int items);
    idle_en = 1'b0;
    repeat (items) send_random(9, 6, 4, 1);
  endtask

  // Result channel: random stall bursts while idling is allowed.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!idle_en) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Each result transfer is compared with the oldest pending expectation.
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: tdata %h tuser %b",
               out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.ok) begin
          $error("ok mismatch: expected %b, actual %b", want.ok, out_tuser[0]);
          fail_count++;
        end
        if (out_tdata[31:0] !== want.key) begin
          $error("key_out mismatch: expected %h, actual %h", want.key, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[63:32] !== want.value) begin
          $error("value_out mismatch: expected %h, actual %h", want.value, out_tdata[63:32]);
          fail_count++;
        end
        if (out_tdata[68:64] !== want.count) begin
          $error("entry_count mismatch: expected %0d, actual %0d", want.count,
                 out_tdata[68:64]);
          fail_count++;
        end
        if (out_tdata[OUT_DATA_W-1:69] !== '0) begin
          $error("pad mismatch: expected %h, actual %h", 3'b000, out_tdata[OUT_DATA_W-1:69]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without any transfer means the block is stuck.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end
    shadow_head = 0;
    shadow_tail = 0;
    shadow_count = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ukfq_pkg::OP_PUSH;
    // Reset is held low from time zero and released once, for the whole run.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_extremes();
    test_fill_and_drain(8);
    test_random_mix(400);
    test_back_to_back(300);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ukfq_pkg.sv
hdl/ukfq_ram.sv
hdl/ukfq_front.sv
hdl/ukfq_back.sv
hdl/unique_key_fifo_queue_top.sv
sim/unique_key_fifo_queue_top_tb.sv
